// ===== rtl/mvbm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvbm_pkg
// Shared types, codes and sizes of the matrix-vector multiply-accumulate block.
// ----------------------------------------------------------------------------
`default_nettype none

package mvbm_pkg;

  // Store sizes
  localparam int ROWS      = 256;
  localparam int ROW_AW    = 8;
  localparam int VEC_DEPTH = 256;
  localparam int VEC_AW    = 8;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int COL_W   = 12;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 64;
  localparam int FRAC_W  = 16;
  localparam int RCNT_W  = 9;
  localparam int SEG_W   = 9;
  localparam int RLEN_W  = 13;
  localparam int OFFS_W  = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET  = 4'd3;

  localparam logic [RCNT_W-1:0] ROW_COUNT_RST      = 9'd256;
  localparam logic [SEG_W-1:0]  SEGMENT_LENGTH_RST = 9'd256;
  localparam logic [RLEN_W-1:0] ROW_LENGTH_RST     = 13'd4096;
  localparam logic [OFFS_W-1:0] COLUMN_OFFSET_RST  = 12'd0;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MATRIX = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Queue word kinds
  localparam logic [1:0] K_LOAD  = 2'd0;
  localparam logic [1:0] K_ELEM  = 2'd1;
  localparam logic [1:0] K_CLEAR = 2'd2;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [RCNT_W-1:0] row_count;
    logic [SEG_W-1:0]  segment_length;
    logic [RLEN_W-1:0] row_length;
    logic [OFFS_W-1:0] column_offset;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [ROW_AW-1:0]       row;
    logic [VEC_AW-1:0]       vaddr;
    logic                    in_win;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } q_entry_t;

  typedef struct packed {
    logic adv;
    logic s2_busy;
    logic s3_busy;
    logic clear_fire;
    logic wb_valid;
  } bk_status_t;

endpackage

`default_nettype wire

// ===== rtl/mvbm_channels.sv =====
// ----------------------------------------------------------------------------
// mvbm channels
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvbm_item_if;
  logic                                      valid;
  logic                                      ready;
  logic [mvbm_pkg::ACT_W-1:0]                action;
  logic [mvbm_pkg::ROW_AW-1:0]               index;
  logic [mvbm_pkg::COL_W-1:0]                column;
  logic signed [mvbm_pkg::VAL_W-1:0]         value;
  logic                                      last_in_row;

  modport source (output valid, action, index, column, value, last_in_row, input ready);
  modport sink   (input valid, action, index, column, value, last_in_row, output ready);
endinterface

interface mvbm_result_if;
  logic                              valid;
  logic                              ready;
  logic [mvbm_pkg::ROW_AW-1:0]       row;
  logic signed [mvbm_pkg::SUM_W-1:0] row_sum;
  logic                              saturated;

  modport source (output valid, row, row_sum, saturated, input ready);
  modport sink   (input valid, row, row_sum, saturated, output ready);
endinterface

interface mvbm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mvbm_pkg::CFG_IDX_W-1:0]   index;
  logic [mvbm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mvbm_front.sv =====
// ----------------------------------------------------------------------------
// mvbm_front
// Classifies incoming words: loads, clears and in-range matrix elements go to
// the queue with their window check done; everything else is dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module mvbm_front (
  mvbm_item_if.sink            item,
  input  mvbm_pkg::cfg_regs_t  regs,
  input  logic                 push_ready,
  output logic                 push_valid,
  output mvbm_pkg::q_entry_t   push_data
);
  import mvbm_pkg::*;

  logic              row_ok;
  logic              col_ok;
  logic [COL_W-1:0]  col_gap;
  logic              gap_ok;
  logic              keep;

  assign row_ok = {1'b0, item.index} < regs.row_count;
  assign col_ok = ({1'b0, item.column} < regs.row_length) &&
                  (item.column >= regs.column_offset);
  assign col_gap = item.column - regs.column_offset;
  // window end is the segment length, capped by the store size
  assign gap_ok = (col_gap < {{(COL_W-SEG_W){1'b0}}, regs.segment_length}) &&
                  (col_gap[COL_W-1:VEC_AW] == '0);

  always_comb begin
    push_data        = '0;
    push_data.row    = item.index;
    push_data.value  = item.value;
    push_data.last   = item.last_in_row;
    push_data.in_win = col_ok && gap_ok;
    keep             = 1'b0;
    unique case (item.action)
      ACT_LOAD: begin
        push_data.kind  = K_LOAD;
        push_data.vaddr = item.index;
        keep            = 1'b1;
      end
      ACT_MATRIX: begin
        push_data.kind  = K_ELEM;
        push_data.vaddr = col_gap[VEC_AW-1:0];
        keep            = row_ok;
      end
      ACT_CLEAR: begin
        push_data.kind = K_CLEAR;
        keep           = 1'b1;
      end
      default: begin
        // unused action: accept and drop
        keep = 1'b0;
      end
    endcase
  end

  assign item.ready = push_ready;
  assign push_valid = item.valid && keep;

endmodule

`default_nettype wire

// ===== rtl/mvbm_queue.sv =====
// ----------------------------------------------------------------------------
// mvbm_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mvbm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  mvbm_pkg::q_entry_t  push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mvbm_pkg::q_entry_t  pop_data
);
  import mvbm_pkg::*;

  q_entry_t        entries [Q_DEPTH];
  logic [Q_AW-1:0] head;
  logic [Q_AW-1:0] tail;
  logic [Q_AW:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = count != Q_DEPTH[Q_AW:0];
  assign pop_valid  = count != '0;
  assign pop_data   = entries[head];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mvbm_back.sv =====
// ----------------------------------------------------------------------------
// mvbm_back
// Executes queued words: vector store writes, clears, and the three-stage
// multiply-accumulate path (read, multiply, saturating add and write back).
// ----------------------------------------------------------------------------
`default_nettype none

module mvbm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  mvbm_pkg::q_entry_t   pop_data,
  mvbm_result_if.source        result,
  output mvbm_pkg::bk_status_t status
);
  import mvbm_pkg::*;

  // Stores
  logic signed [VAL_W-1:0] vec_mem [VEC_DEPTH];
  logic [SUM_W:0]          sum_mem [ROWS];
  logic [ROWS-1:0]         sum_vld;

  logic adv;
  logic fire;
  logic is_clear;
  logic clear_fire;

  // Stage 2
  logic                    s2_vld;
  logic [ROW_AW-1:0]       s2_row;
  logic                    s2_win;
  logic                    s2_last;
  logic signed [VAL_W-1:0] s2_val;
  logic signed [VAL_W-1:0] vec_rd;
  logic [SUM_W:0]          sum_rd;
  logic                    rd_vld;
  logic                    fwd2;
  logic [SUM_W-1:0]        base2_sum;
  logic                    base2_sat;

  // Stage 3
  logic                    s3_vld;
  logic [ROW_AW-1:0]       s3_row;
  logic                    s3_win;
  logic                    s3_last;
  logic [SUM_W-1:0]        s3_sum;
  logic                    s3_sat;
  logic signed [SUM_W-1:0] s3_prod;
  logic                    fwd3;
  logic [SUM_W-1:0]        base;
  logic                    base_sat;
  logic [SUM_W-1:0]        addend;
  logic [SUM_W-1:0]        sum_raw;
  logic                    ovf;
  logic [SUM_W-1:0]        new_sum;
  logic                    new_sat;
  logic                    s3_write;

  // Last write-back, always the current content of its row
  logic                    wb_vld;
  logic [ROW_AW-1:0]       wb_row;
  logic [SUM_W-1:0]        wb_sum;
  logic                    wb_sat;

  assign adv        = !result.valid || result.ready;
  assign is_clear   = pop_data.kind == K_CLEAR;
  // a clear waits until nothing is in flight
  assign pop_ready  = adv && (!is_clear || (!s2_vld && !s3_vld));
  assign fire       = pop_valid && pop_ready;
  assign clear_fire = fire && is_clear;
  assign s3_write   = adv && s3_vld;

  // Vector store
  always_ff @(posedge clk) begin
    if (fire && (pop_data.kind == K_LOAD)) begin
      vec_mem[pop_data.vaddr] <= pop_data.value;
    end
    if (adv) begin
      vec_rd <= vec_mem[pop_data.vaddr];
    end
  end

  // Row sum store, sticky flag in the top bit
  always_ff @(posedge clk) begin
    if (s3_write) begin
      sum_mem[s3_row] <= {new_sat, new_sum};
    end
    if (adv) begin
      sum_rd <= sum_mem[pop_data.row];
      rd_vld <= sum_vld[pop_data.row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_fire) begin
      sum_vld <= '0;
    end else if (s3_write) begin
      sum_vld[s3_row] <= 1'b1;
    end
  end

  // Stage 2: patch in the write that landed after the read, then multiply
  assign fwd2      = wb_vld && (wb_row == s2_row);
  assign base2_sum = fwd2 ? wb_sum : (rd_vld ? sum_rd[SUM_W-1:0] : '0);
  assign base2_sat = fwd2 ? wb_sat : (rd_vld && sum_rd[SUM_W]);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_row  <= pop_data.row;
      s2_win  <= pop_data.in_win;
      s2_last <= pop_data.last;
      s2_val  <= pop_data.value;
      s3_row  <= s2_row;
      s3_win  <= s2_win;
      s3_last <= s2_last;
      s3_sum  <= base2_sum;
      s3_sat  <= base2_sat;
      s3_prod <= SUM_W'(s2_val * vec_rd);
    end
  end

  // Stage 3: floor the product to Q48.16 and add with saturation
  assign fwd3     = wb_vld && (wb_row == s3_row);
  assign base     = fwd3 ? wb_sum : s3_sum;
  assign base_sat = fwd3 ? wb_sat : s3_sat;
  assign addend   = s3_win ? {{FRAC_W{s3_prod[SUM_W-1]}}, s3_prod[SUM_W-1:FRAC_W]} : '0;
  assign sum_raw  = base + addend;
  assign ovf      = (base[SUM_W-1] == addend[SUM_W-1]) &&
                    (sum_raw[SUM_W-1] != base[SUM_W-1]);
  assign new_sum  = ovf ? (base[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_raw;
  assign new_sat  = base_sat || ovf;

  always_ff @(posedge clk) begin
    if (s3_write) begin
      wb_row <= s3_row;
      wb_sum <= new_sum;
      wb_sat <= new_sat;
    end
    if (s3_write && s3_last) begin
      result.row       <= s3_row;
      result.row_sum   <= new_sum;
      result.saturated <= new_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld       <= 1'b0;
      s3_vld       <= 1'b0;
      wb_vld       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (adv) begin
        s2_vld       <= fire && (pop_data.kind == K_ELEM);
        s3_vld       <= s2_vld;
        result.valid <= s3_vld && s3_last;
      end
      if (clear_fire) begin
        wb_vld <= 1'b0;
      end else if (s3_write) begin
        wb_vld <= 1'b1;
      end
    end
  end

  assign status.adv        = adv;
  assign status.s2_busy    = s2_vld;
  assign status.s3_busy    = s3_vld;
  assign status.clear_fire = clear_fire;
  assign status.wb_valid   = wb_vld;

endmodule

`default_nettype wire

// ===== rtl/matrix_vector_block_mac.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_block_mac: Q16.16 matrix-vector MAC, one word per cycle unless stalled
// Path: a word passes the queue, read, multiply and add stages before its row result is valid.
// Throughput: 1 word per cycle while results are taken; a clear waits for the MAC pipe to drain.
// Reset: sums and flags read zero at once, queue empties, registers take defaults; vector undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_vector_block_mac (
  input  logic          clk,
  input  logic          rst,
  mvbm_item_if.sink     item,
  mvbm_result_if.source result,
  mvbm_cfg_if.sink      cfg
);
  import mvbm_pkg::*;

  cfg_regs_t  regs;
  logic       push_valid;
  logic       push_ready;
  q_entry_t   push_data;
  logic       pop_valid;
  logic       pop_ready;
  q_entry_t   pop_data;
  bk_status_t bk_status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.row_count      <= ROW_COUNT_RST;
      regs.segment_length <= SEGMENT_LENGTH_RST;
      regs.row_length     <= ROW_LENGTH_RST;
      regs.column_offset  <= COLUMN_OFFSET_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROW_COUNT:      regs.row_count      <= cfg.data[RCNT_W-1:0];
        REG_SEGMENT_LENGTH: regs.segment_length <= cfg.data[SEG_W-1:0];
        REG_ROW_LENGTH:     regs.row_length     <= cfg.data[RLEN_W-1:0];
        REG_COLUMN_OFFSET:  regs.column_offset  <= cfg.data[OFFS_W-1:0];
        default: begin
          // drop writes past the register list
          regs <= regs;
        end
      endcase
    end
  end

  mvbm_front u_front (
    .item       (item),
    .regs       (regs),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  mvbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mvbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result),
    .status    (bk_status)
  );

  a_reset_defaults : assert property (@(posedge clk)
    $past(rst) |-> (regs.row_count == ROW_COUNT_RST) && (regs.row_length == ROW_LENGTH_RST))
    else $error("register defaults not restored by reset");

  a_clear_drained : assert property (@(posedge clk) disable iff (rst)
    bk_status.clear_fire |-> !bk_status.s2_busy && !bk_status.s3_busy)
    else $error("clear taken with multiply-accumulate words in flight");

  a_clear_drops_fwd : assert property (@(posedge clk) disable iff (rst)
    bk_status.clear_fire |=> !bk_status.wb_valid)
    else $error("write-back bypass survived a clear");

  a_result_from_pipe : assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(bk_status.adv) && $past(bk_status.s3_busy))
    else $error("result appeared without a word leaving the add stage");

endmodule

`default_nettype wire
